[sv/pc_pkg.sv]
`default_nettype none

package pc_pkg;

  // counter width of the running totals
  localparam int CountWidth = 16;
  // width of the count fields on the result channel
  localparam int OutWidth   = 16;
  localparam int ErrWidth   = 9;

  typedef logic [CountWidth-1:0] count_t;

  // byte codes
  localparam logic [7:0] EndOfText = 8'h1A;
  localparam logic [7:0] CarRet    = 8'h0D;
  localparam logic [7:0] CarRetHi  = 8'h8D;
  localparam logic [7:0] LineFeed  = 8'h0A;
  localparam logic [6:0] Tab       = 7'h09;
  localparam logic [6:0] Space     = 7'h20;
  localparam logic [6:0] Bang      = 7'h21;
  localparam logic [6:0] Quote     = 7'h22;
  localparam logic [6:0] LParen    = 7'h28;
  localparam logic [6:0] RParen    = 7'h29;
  localparam logic [6:0] Comma     = 7'h2C;
  localparam logic [6:0] Period    = 7'h2E;
  localparam logic [6:0] Question  = 7'h3F;
  localparam logic [6:0] UpperZ    = 7'h5A;

  // operation codes
  localparam logic OpText    = 1'b0;
  localparam logic OpRestart = 1'b1;

  // error_mask bit positions
  localparam int ErrNoSpacePeriod   = 0;
  localparam int ErrNoSpaceBang     = 1;
  localparam int ErrNoSpaceQuestion = 2;
  localparam int ErrNoSpaceComma    = 3;
  localparam int ErrSpacePeriod     = 4;
  localparam int ErrSpaceQuestion   = 5;
  localparam int ErrSpaceBang       = 6;
  localparam int ErrSpaceComma      = 7;
  localparam int ErrUncapitalized   = 8;

  typedef struct packed {
    logic [6:0] prev_char;
    logic       sentence_start;
    count_t     line_count;
    count_t     char_count;
    count_t     left_count;
    count_t     right_count;
    count_t     quote_count;
    logic       ended;
  } state_t;

  localparam state_t StateReset = '{
    prev_char:      Space,
    sentence_start: 1'b1,
    line_count:     count_t'(1),
    char_count:     count_t'(1),
    left_count:     '0,
    right_count:    '0,
    quote_count:    '0,
    ended:          1'b0
  };

endpackage

`default_nettype wire

[sv/pc_in_if.sv]
`default_nettype none

interface pc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;

  modport source (output valid, output operation, output char_code, input ready);
  modport sink   (input valid, input operation, input char_code, output ready);
endinterface

`default_nettype wire

[sv/pc_out_if.sv]
`default_nettype none

interface pc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pc_pkg::ErrWidth-1:0]   error_mask;
  logic [pc_pkg::OutWidth-1:0]   line_number;
  logic [pc_pkg::OutWidth-1:0]   char_total;
  logic [pc_pkg::OutWidth-1:0]   left_parens;
  logic [pc_pkg::OutWidth-1:0]   right_parens;
  logic [pc_pkg::OutWidth-1:0]   quote_total;
  logic                          parens_unbalanced;
  logic                          quotes_odd;
  logic                          text_ended;

  modport source (
    output valid, output error_mask, output line_number, output char_total,
    output left_parens, output right_parens, output quote_total,
    output parens_unbalanced, output quotes_odd, output text_ended,
    input ready
  );
  modport sink (
    input valid, input error_mask, input line_number, input char_total,
    input left_parens, input right_parens, input quote_total,
    input parens_unbalanced, input quotes_odd, input text_ended,
    output ready
  );
endinterface

`default_nettype wire

[sv/pc_step.sv]
`default_nettype none

// next-state and fault logic for one byte
module pc_step (
  input  logic                        operation_i,
  input  logic [7:0]                  char_code_i,
  input  pc_pkg::state_t              state_i,
  output pc_pkg::state_t              state_o,
  output logic [pc_pkg::ErrWidth-1:0] error_mask_o
);

  logic [6:0] c;
  logic [6:0] p;

  always_comb begin
    c = char_code_i[6:0];
    if (c == pc_pkg::Tab) begin
      c = pc_pkg::Space;
    end
    p            = state_i.prev_char;
    state_o      = state_i;
    error_mask_o = '0;

    if (operation_i == pc_pkg::OpRestart) begin
      state_o = pc_pkg::StateReset;
    end else if (!state_i.ended) begin
      if (char_code_i == pc_pkg::EndOfText) begin
        state_o.ended = 1'b1;
      end else if (char_code_i == pc_pkg::CarRet || char_code_i == pc_pkg::CarRetHi) begin
        state_o.line_count = state_i.line_count + pc_pkg::count_t'(1);
        state_o.prev_char  = pc_pkg::Space;
      end else if (char_code_i != pc_pkg::LineFeed) begin
        state_o.char_count = state_i.char_count + pc_pkg::count_t'(1);

        // mark not followed by a space
        if (c != pc_pkg::Space) begin
          error_mask_o[pc_pkg::ErrNoSpacePeriod]   = (p == pc_pkg::Period);
          error_mask_o[pc_pkg::ErrNoSpaceBang]     = (p == pc_pkg::Bang);
          error_mask_o[pc_pkg::ErrNoSpaceQuestion] = (p == pc_pkg::Question);
          error_mask_o[pc_pkg::ErrNoSpaceComma]    = (p == pc_pkg::Comma);
        end
        // space in front of a mark
        if (p == pc_pkg::Space) begin
          error_mask_o[pc_pkg::ErrSpacePeriod]   = (c == pc_pkg::Period);
          error_mask_o[pc_pkg::ErrSpaceQuestion] = (c == pc_pkg::Question);
          error_mask_o[pc_pkg::ErrSpaceBang]     = (c == pc_pkg::Bang);
          error_mask_o[pc_pkg::ErrSpaceComma]    = (c == pc_pkg::Comma);
        end
        error_mask_o[pc_pkg::ErrUncapitalized] =
          state_i.sentence_start && (c != pc_pkg::Space) && (c > pc_pkg::UpperZ);

        if (state_i.sentence_start && c > pc_pkg::Bang) begin
          state_o.sentence_start = 1'b0;
        end
        if (c inside {pc_pkg::Period, pc_pkg::Bang, pc_pkg::Question}) begin
          state_o.sentence_start = 1'b1;
        end

        if (c == pc_pkg::LParen) begin
          state_o.left_count = state_i.left_count + pc_pkg::count_t'(1);
        end
        if (c == pc_pkg::RParen) begin
          state_o.right_count = state_i.right_count + pc_pkg::count_t'(1);
        end
        if (c == pc_pkg::Quote) begin
          state_o.quote_count = state_i.quote_count + pc_pkg::count_t'(1);
        end

        state_o.prev_char = c;
      end
    end
  end

endmodule

`default_nettype wire

[sv/punctuation_checker.sv]
// Punctuation checker: takes one text byte per input item and returns one
// result item per byte with fault bits for that byte (missing space after or
// space before '.', '!', '?', ',' and a lower-case sentence start) plus the
// running line, character, parenthesis and quote totals. Operation 1 restarts
// the block to its reset state. A byte is taken in every cycle in which the
// input is ready: the next state and the result are formed in one pass of
// compare and increment logic and land together in the state and result
// registers, so the result is valid in the cycle after the byte is accepted.
// The input is ready whenever the result register is empty or its item is
// being taken in the same cycle, so the sustained rate is one item per cycle
// as long as the result side takes one item per cycle.
`default_nettype none

module punctuation_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pc_in_if.sink      in_i,
  pc_out_if.source   out_o
);

  // checker state after every accepted item
  pc_pkg::state_t              state_q;
  pc_pkg::state_t              state_d;
  // result register: fault bits plus a snapshot of the totals
  pc_pkg::state_t              res_state_q;
  logic [pc_pkg::ErrWidth-1:0] err_q;
  logic [pc_pkg::ErrWidth-1:0] err_d;
  logic                        out_valid_q;
  logic                        in_fire;

  // accept while the result slot is free or draining this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  pc_step u_step (
    .operation_i  (in_i.operation),
    .char_code_i  (in_i.char_code),
    .state_i      (state_q),
    .state_o      (state_d),
    .error_mask_o (err_d)
  );

  // control and checker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pc_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_state_q <= state_d;
      err_q       <= err_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.error_mask        = err_q;
  assign out_o.line_number       = pc_pkg::OutWidth'(res_state_q.line_count);
  assign out_o.char_total        = pc_pkg::OutWidth'(res_state_q.char_count);
  assign out_o.left_parens       = pc_pkg::OutWidth'(res_state_q.left_count);
  assign out_o.right_parens      = pc_pkg::OutWidth'(res_state_q.right_count);
  assign out_o.quote_total       = pc_pkg::OutWidth'(res_state_q.quote_count);
  // compared on the full counters
  assign out_o.parens_unbalanced = (res_state_q.left_count != res_state_q.right_count);
  assign out_o.quotes_odd        = res_state_q.quote_count[0];
  assign out_o.text_ended        = res_state_q.ended;

endmodule

`default_nettype wire
